// ===== rtl/hlc_pkg.sv =====
// ============================================================================
// hlc_pkg - shared types and constants for the Hamming leader clustering block
// Holds field widths, register indexes, the controller states and the structs
// that travel between the controller and the row of parent cells.
// ============================================================================
package hlc_pkg;

	localparam int WORD_W     = 64;
	localparam int ACC_W      = 11;
	localparam int IDX_W      = 8;
	localparam int KMER_W     = 11;
	localparam int THR_W      = 11;
	localparam int TOTAL_W    = 16;
	localparam int SEQ_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEQ_TOTAL     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COMPRESS      = 2'd3;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_LAST,
		ST_SCAN,
		ST_COPY,
		ST_FINISH
	} state_t;

	// best candidate so far, handed from cell to cell during the scan
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [ACC_W-1:0] distance;
	} cand_t;

	// controls broadcast from the controller to every cell
	typedef struct packed {
		logic             acc_en;
		logic             acc_clr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_slot;
		logic [THR_W-1:0] threshold;
	} cell_ctrl_t;

endpackage

// ===== rtl/hlc_cell.sv =====
// ============================================================================
// hlc_cell - one parent slot of the clustering row
// Stores one parent row, accumulates its distance to the streaming row and
// updates the best candidate handed in from the previous cell.
// ============================================================================
module hlc_cell #(
	parameter int IDX       = 0,
	parameter int ROW_WORDS = 16,
	parameter int WW        = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hlc_pkg::cell_ctrl_t          ctrl,
	input  logic                         active,
	input  logic [hlc_pkg::WORD_W-1:0]   word_s1,
	input  logic [WW-1:0]                rd_addr,
	input  logic [WW-1:0]                wr_addr,
	input  logic [hlc_pkg::WORD_W-1:0]   wr_data,
	input  hlc_pkg::cand_t               cand_in,
	output hlc_pkg::cand_t               cand_out
);

	logic [hlc_pkg::WORD_W-1:0] mem [ROW_WORDS];
	logic [hlc_pkg::WORD_W-1:0] rd_q;
	logic [hlc_pkg::ACC_W-1:0]  acc_q;
	logic [hlc_pkg::ACC_W-1:0]  acc_d;
	logic [hlc_pkg::ACC_W:0]    sum;
	logic [6:0]                 ones;
	logic [hlc_pkg::WORD_W-1:0] diff;
	logic                       take;
	hlc_pkg::cand_t             cand_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && ctrl.wr_slot == hlc_pkg::IDX_W'(IDX)) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		diff = word_s1 ^ rd_q;
		ones = '0;
		for (int b = 0; b < hlc_pkg::WORD_W; b++) begin
			ones = ones + 7'(diff[b]);
		end
		sum   = {1'b0, acc_q} + (hlc_pkg::ACC_W + 1)'(ones);
		acc_d = sum[hlc_pkg::ACC_W] ? hlc_pkg::ACC_MAX : sum[hlc_pkg::ACC_W-1:0];
		take  = active && (acc_q <= ctrl.threshold) &&
		        (!cand_in.found || acc_q < cand_in.distance);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cand_q <= '0;
		end else begin
			if (ctrl.acc_clr) begin
				acc_q <= '0;
			end else if (ctrl.acc_en) begin
				acc_q <= acc_d;
			end
			// take over the candidate when this active parent is within the threshold and strictly closer
			if (take) begin
				cand_q.found    <= 1'b1;
				cand_q.idx      <= hlc_pkg::IDX_W'(IDX);
				cand_q.distance <= acc_q;
			end else begin
				cand_q <= cand_in;
			end
		end
	end

	assign cand_out = cand_q;

endmodule

// ===== rtl/hamming_leader_clustering.sv =====
// ============================================================================
// hamming_leader_clustering - greedy leader clustering of bit rows
// Streams rows as 64-bit words, compares each row against stored parent rows
// in a row of cells and reports the cluster that the row joins or founds.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall, row_word): one request per 64-bit word
//   of a row, bit 0 first; the last word is masked to the configured bit count.
//   Output channel (out_valid / out_stall): one request per finished row.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is
//   always high; write only while no row result is pending.
// Flow:
//   Words of a row are taken one per cycle while in_stall is low; every cell
//   compares the broadcast word against its own parent word in parallel. After
//   the last word the input stalls for the closing of the row: accumulation
//   finishes, the best candidate ripples down the cell chain, the row is copied
//   into a new parent slot when it founds one, and the result register is
//   loaded once the output is free. With compression off the closing skips the
//   scan and the copy. The result register is free again once the receiver takes
//   it; a stalled result holds, and input words still stream in meanwhile.
// Reset: clears accumulators, counters and the parent count; registers come
//   up at 1024 bits per row, threshold 0, sequence_total 1, compression on.
// ============================================================================
module hamming_leader_clustering #(
	parameter int MAX_PARENTS = 32,
	parameter int ROW_BITS    = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [hlc_pkg::WORD_W-1:0]        row_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [hlc_pkg::SEQ_W-1:0]         sequence_index,
	output logic [hlc_pkg::SEQ_W-1:0]         cluster_index,
	output logic [hlc_pkg::ACC_W-1:0]         hamming_distance,
	output logic                              new_parent,
	output logic                              store_full,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hlc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hlc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int ROW_WORDS = (ROW_BITS + 63) / 64;
	localparam int WW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
	localparam int PCW       = $clog2(MAX_PARENTS + 1);
	localparam int BW        = ($clog2(ROW_BITS + 1) > hlc_pkg::KMER_W) ?
	                           $clog2(ROW_BITS + 1) : hlc_pkg::KMER_W;

	// configuration registers
	logic [hlc_pkg::KMER_W-1:0]  kmer_q;
	logic [hlc_pkg::THR_W-1:0]   thr_q;
	logic [hlc_pkg::TOTAL_W-1:0] total_q;
	logic                        compress_q;

	// control state
	hlc_pkg::state_t             state_q, state_d;
	logic [WW-1:0]               wc_q;
	logic [WW-1:0]               cw_q;
	logic [PCW-1:0]              cnt_q;
	logic [PCW-1:0]              pc_q;
	logic [hlc_pkg::SEQ_W-1:0]   rc_q;
	logic                        valid_s1;
	logic                        cp_v_s1;
	logic                        out_valid_q;

	// payload
	logic [hlc_pkg::WORD_W-1:0]  word_s1;
	logic [WW-1:0]               cp_addr_s1;
	logic                        cp_zero_s1;
	logic [hlc_pkg::WORD_W-1:0]  buf_rd_q;
	logic [hlc_pkg::WORD_W-1:0]  row_buf [ROW_WORDS];
	logic [hlc_pkg::SEQ_W-1:0]   res_cluster_q;
	logic [hlc_pkg::ACC_W-1:0]   res_dist_q;
	logic                        res_new_q;
	logic                        res_full_q;
	logic                        res_inc_q;
	logic [hlc_pkg::SEQ_W-1:0]   seq_q;
	logic [hlc_pkg::SEQ_W-1:0]   clu_q;
	logic [hlc_pkg::ACC_W-1:0]   dist_q;
	logic                        newp_q;
	logic                        full_q;

	// combinational
	logic                        accept;
	logic                        out_free;
	logic                        scan_done;
	logic                        finish;
	logic [BW-1:0]               bits_raw;
	logic [BW-1:0]               bits_eff;
	logic [BW-1:0]               bits_m1;
	logic [BW-1:0]               last_w;
	logic                        is_last;
	logic [hlc_pkg::WORD_W-1:0]  word_m;
	logic [hlc_pkg::SEQ_W-1:0]   rc_inc;
	logic [hlc_pkg::TOTAL_W-1:0] total_eff;
	hlc_pkg::cell_ctrl_t         ctrl;
	hlc_pkg::cand_t              chain [MAX_PARENTS+1];
	hlc_pkg::cand_t              best;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != hlc_pkg::ST_RUN);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign best      = chain[MAX_PARENTS];
	assign scan_done = (state_q == hlc_pkg::ST_SCAN) && (cnt_q == PCW'(MAX_PARENTS));
	assign finish    = (state_q == hlc_pkg::ST_FINISH) && out_free;

	// clamp the bit count, find the last word of the row and mask its tail
	always_comb begin
		bits_raw = BW'(kmer_q);
		if (bits_raw == '0) begin
			bits_eff = BW'(1);
		end else if (bits_raw > BW'(ROW_BITS)) begin
			bits_eff = BW'(ROW_BITS);
		end else begin
			bits_eff = bits_raw;
		end
		bits_m1 = bits_eff - BW'(1);
		last_w  = bits_m1 >> 6;
		is_last = (BW'(wc_q) >= last_w);
		word_m  = is_last ? (row_word & ({hlc_pkg::WORD_W{1'b1}} >> (6'd63 - bits_m1[5:0])))
		                  : row_word;
	end

	always_comb begin
		rc_inc    = rc_q + hlc_pkg::SEQ_W'(1);
		total_eff = (total_q == '0) ? hlc_pkg::TOTAL_W'(1) : total_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hlc_pkg::ST_RUN: begin
				if (accept && is_last) state_d = hlc_pkg::ST_LAST;
			end
			hlc_pkg::ST_LAST: begin
				state_d = compress_q ? hlc_pkg::ST_SCAN : hlc_pkg::ST_FINISH;
			end
			hlc_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = (!best.found && pc_q < PCW'(MAX_PARENTS)) ?
					          hlc_pkg::ST_COPY : hlc_pkg::ST_FINISH;
				end
			end
			hlc_pkg::ST_COPY: begin
				if (cw_q == WW'(ROW_WORDS - 1)) state_d = hlc_pkg::ST_FINISH;
			end
			hlc_pkg::ST_FINISH: begin
				if (out_free) state_d = hlc_pkg::ST_RUN;
			end
			default: state_d = hlc_pkg::ST_RUN;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_q     <= hlc_pkg::KMER_W'(1024);
			thr_q      <= '0;
			total_q    <= hlc_pkg::TOTAL_W'(1);
			compress_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hlc_pkg::REG_BIT_COUNT:  kmer_q     <= cfg_data[hlc_pkg::KMER_W-1:0];
				hlc_pkg::REG_THRESHOLD:  thr_q      <= cfg_data[hlc_pkg::THR_W-1:0];
				hlc_pkg::REG_SEQ_TOTAL:  total_q    <= cfg_data[hlc_pkg::TOTAL_W-1:0];
				hlc_pkg::REG_COMPRESS:   compress_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hlc_pkg::ST_RUN;
			wc_q        <= '0;
			cw_q        <= '0;
			cnt_q       <= '0;
			pc_q        <= '0;
			rc_q        <= '0;
			valid_s1    <= 1'b0;
			cp_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= accept;
			cp_v_s1  <= (state_q == hlc_pkg::ST_COPY);
			if (accept && !is_last) begin
				wc_q <= wc_q + WW'(1);
			end
			if (state_q == hlc_pkg::ST_LAST) begin
				cnt_q <= '0;
				cw_q  <= '0;
			end
			if (state_q == hlc_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + PCW'(1);
			end
			if (state_q == hlc_pkg::ST_COPY) begin
				cw_q <= cw_q + WW'(1);
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				wc_q        <= '0;
				// drop the whole store once the matrix is complete
				if (rc_inc == '0 || rc_inc >= total_eff) begin
					rc_q <= '0;
					pc_q <= '0;
				end else begin
					rc_q <= rc_inc;
					pc_q <= pc_q + PCW'(res_inc_q);
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers and row buffer
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1       <= word_m;
			row_buf[wc_q] <= word_m;
		end
		buf_rd_q   <= row_buf[cw_q];
		cp_addr_s1 <= cw_q;
		cp_zero_s1 <= (cw_q > wc_q);
		if (state_q == hlc_pkg::ST_LAST && !compress_q) begin
			res_cluster_q <= rc_q;
			res_dist_q    <= '0;
			res_new_q     <= 1'b1;
			res_full_q    <= 1'b0;
			res_inc_q     <= 1'b0;
		end
		if (scan_done) begin
			if (best.found) begin
				res_cluster_q <= hlc_pkg::SEQ_W'(best.idx);
				res_dist_q    <= best.distance;
				res_new_q     <= 1'b0;
				res_full_q    <= 1'b0;
				res_inc_q     <= 1'b0;
			end else if (pc_q < PCW'(MAX_PARENTS)) begin
				res_cluster_q <= hlc_pkg::SEQ_W'(pc_q);
				res_dist_q    <= '0;
				res_new_q     <= 1'b1;
				res_full_q    <= 1'b0;
				res_inc_q     <= 1'b1;
			end else begin
				res_cluster_q <= '0;
				res_dist_q    <= '0;
				res_new_q     <= 1'b0;
				res_full_q    <= 1'b1;
				res_inc_q     <= 1'b0;
			end
		end
		if (finish) begin
			seq_q  <= rc_q;
			clu_q  <= res_cluster_q;
			dist_q <= res_dist_q;
			newp_q <= res_new_q;
			full_q <= res_full_q;
		end
	end

	// broadcast controls; words beyond this row's end are stored as zero
	always_comb begin
		ctrl.acc_en    = valid_s1;
		ctrl.acc_clr   = finish;
		ctrl.wr_en     = cp_v_s1;
		ctrl.wr_slot   = hlc_pkg::IDX_W'(pc_q);
		ctrl.threshold = thr_q;
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_PARENTS; i++) begin : g_cell
		hlc_cell #(
			.IDX       (i),
			.ROW_WORDS (ROW_WORDS),
			.WW        (WW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.active   (PCW'(i) < pc_q),
			.word_s1  (word_s1),
			.rd_addr  (wc_q),
			.wr_addr  (cp_addr_s1),
			.wr_data  (cp_zero_s1 ? '0 : buf_rd_q),
			.cand_in  (chain[i]),
			.cand_out (chain[i+1])
		);
	end

	assign out_valid        = out_valid_q;
	assign sequence_index   = seq_q;
	assign cluster_index    = clu_q;
	assign hamming_distance = dist_q;
	assign new_parent       = newp_q;
	assign store_full       = full_q;

endmodule

// ===== sim/tb_hamming_leader_clustering.sv =====
// ============================================================================
// tb_hamming_leader_clustering - self-checking bench for leader clustering
// Streams row words into the block under random source gaps and sink stalls,
// predicts every row result with a behavioral model of the parent store and
// checks each result field by field. Registers change only between phases,
// with the block drained.
// ============================================================================
module tb_hamming_leader_clustering;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PARENTS   = 32;
	localparam int ROW_BITS      = 1024;
	localparam int ROW_WORDS     = (ROW_BITS + 63) / 64;
	localparam int CLK_PERIOD    = 20;
	// closing of a row: accumulate, scan the cell chain, copy, load the result
	localparam int SETTLE_CYCLES = MAX_PARENTS + ROW_WORDS + 12;
	localparam int RANDOM_WORDS  = 850;

	// one finished row as the result port presents it
	typedef struct packed {
		logic [hlc_pkg::SEQ_W-1:0] seq_idx;
		logic [hlc_pkg::SEQ_W-1:0] cluster;
		logic [hlc_pkg::ACC_W-1:0] distance;
		logic                      founded;
		logic                      full;
	} row_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [hlc_pkg::WORD_W-1:0]     row_word = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b1;
	logic [hlc_pkg::SEQ_W-1:0]      sequence_index;
	logic [hlc_pkg::SEQ_W-1:0]      cluster_index;
	logic [hlc_pkg::ACC_W-1:0]      hamming_distance;
	logic                           new_parent;
	logic                           store_full;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [hlc_pkg::CFG_IDX_W-1:0]  cfg_index = hlc_pkg::REG_BIT_COUNT;
	logic [hlc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// register mirror, at reset values
	logic [hlc_pkg::KMER_W-1:0]  kmer_cfg = 11'd1024;
	logic [hlc_pkg::THR_W-1:0]   thr_cfg = '0;
	logic [hlc_pkg::TOTAL_W-1:0] total_cfg = 16'd1;
	logic                        compress_cfg = 1'b1;

	// model of the parent store and the row in progress
	bit [hlc_pkg::WORD_W-1:0]  parent_mem [MAX_PARENTS][ROW_WORDS];
	bit [hlc_pkg::WORD_W-1:0]  row_buf [ROW_WORDS];
	int                        acc [MAX_PARENTS];
	int                        n_parents = 0;
	int                        word_pos = 0;
	logic [hlc_pkg::SEQ_W-1:0] row_pos = '0;

	logic [hlc_pkg::WORD_W-1:0] word_queue [$];
	row_result_t                expected_rows [$];
	int                         words_pushed = 0;
	int                         words_taken = 0;
	int                         error_count = 0;
	int                         send_gap = 0;
	int                         hold_left = 0;
	bit                         word_taken = 1'b0;
	bit                         quiet_phase = 1'b0;

	hamming_leader_clustering #(
		.MAX_PARENTS(MAX_PARENTS),
		.ROW_BITS   (ROW_BITS)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.row_word        (row_word),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sequence_index  (sequence_index),
		.cluster_index   (cluster_index),
		.hamming_distance(hamming_distance),
		.new_parent      (new_parent),
		.store_full      (store_full),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Mostly short gaps, a few long ones; none at all in a quiet phase.
	function automatic int pick_gap();
		int r;
		if (quiet_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [hlc_pkg::WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Fold one accepted word into the model; return 1 with the row result
	// when this word closes the row.
	function automatic bit classify_word(input logic [hlc_pkg::WORD_W-1:0] word_in,
	                                     output row_result_t res);
		logic [hlc_pkg::WORD_W-1:0] w;
		int bits, last_w, tail, p, k, sum, best, best_d, limit;
		bit closing;
		w = word_in;
		res = '0;
		// out-of-range bit counts clamp to 1 and to the row width
		bits = (kmer_cfg == 0) ? 1 : ((kmer_cfg > ROW_BITS) ? ROW_BITS : int'(kmer_cfg));
		last_w = (bits - 1) / 64;
		// a row ends at or past its last word, even when the count shrank mid-row
		closing = (word_pos >= last_w);
		if (closing) begin
			tail = bits - last_w * 64;
			if (tail < 64)
				w &= (64'd1 << tail) - 64'd1;
		end
		if (word_pos >= ROW_WORDS)
			word_pos = ROW_WORDS - 1;
		row_buf[word_pos] = w;
		for (p = 0; p < n_parents; p++) begin
			sum = acc[p] + $countones(w ^ parent_mem[p][word_pos]);
			acc[p] = (sum > int'(hlc_pkg::ACC_MAX)) ? int'(hlc_pkg::ACC_MAX) : sum;
		end
		if (!closing) begin
			word_pos++;
			return 1'b0;
		end
		res.seq_idx = row_pos;
		if (!compress_cfg) begin
			// every row founds its own cluster; the store is left alone
			res.cluster = row_pos;
			res.founded = 1'b1;
		end else begin
			best = -1;
			best_d = 0;
			for (p = 0; p < n_parents; p++)
				if (acc[p] <= int'(thr_cfg) && (best < 0 || acc[p] < best_d)) begin
					best = p;
					best_d = acc[p];
				end
			if (best >= 0) begin
				res.cluster = hlc_pkg::SEQ_W'(best);
				res.distance = hlc_pkg::ACC_W'(best_d);
			end else if (n_parents < MAX_PARENTS) begin
				// words not written in this row go in as zero
				for (k = 0; k < ROW_WORDS; k++)
					parent_mem[n_parents][k] = (k <= word_pos) ? row_buf[k] : '0;
				res.cluster = hlc_pkg::SEQ_W'(n_parents);
				res.founded = 1'b1;
				n_parents++;
			end else begin
				res.full = 1'b1;
			end
		end
		for (p = 0; p < MAX_PARENTS; p++)
			acc[p] = 0;
		word_pos = 0;
		row_pos++;
		// a zero total acts as one; a lowered total clears at the next row
		limit = (total_cfg == 0) ? 1 : int'(total_cfg);
		if (row_pos == 0 || int'(row_pos) >= limit) begin
			row_pos = '0;
			n_parents = 0;
		end
		return 1'b1;
	endfunction

	// Source driver: hold a request until taken, then advance after its gap.
	always @(negedge clk) begin
		if (!in_valid || word_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (word_queue.size() != 0) begin
				row_word <= word_queue.pop_front();
				in_valid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Sink stalls: random runs of stall between open cycles.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			hold_left = pick_gap();
		end
	end

	// Monitor: predict on every accepted word request, check every result.
	always @(posedge clk) begin : monitor_p
		row_result_t want;
		row_result_t got;
		word_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				word_taken = 1'b1;
				words_taken++;
				if (classify_word(row_word, want))
					expected_rows.insert(expected_rows.size(), want);
			end
			if (out_valid && !out_stall) begin
				got = {sequence_index, cluster_index, hamming_distance, new_parent,
				       store_full};
				if (expected_rows.size() == 0) begin
					$error("unexpected row result: sequence_index %0d", sequence_index);
					error_count++;
				end else begin
					want = expected_rows.pop_front();
					if (got.seq_idx !== want.seq_idx) begin
						$error("sequence_index: expected %0d, actual %0d",
						       want.seq_idx, got.seq_idx);
						error_count++;
					end
					if (got.cluster !== want.cluster) begin
						$error("cluster_index: expected %0d, actual %0d",
						       want.cluster, got.cluster);
						error_count++;
					end
					if (got.distance !== want.distance) begin
						$error("hamming_distance: expected %0d, actual %0d",
						       want.distance, got.distance);
						error_count++;
					end
					if (got.founded !== want.founded) begin
						$error("new_parent: expected %0b, actual %0b",
						       want.founded, got.founded);
						error_count++;
					end
					if (got.full !== want.full) begin
						$error("store_full: expected %0b, actual %0b",
						       want.full, got.full);
						error_count++;
					end
				end
			end
		end
	end

	task automatic push_word(input logic [hlc_pkg::WORD_W-1:0] w);
		word_queue.insert(word_queue.size(), w);
		words_pushed++;
	endtask

	// Write one register; cfg_valid stays high for a following write.
	task automatic write_reg(input logic [hlc_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [hlc_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			hlc_pkg::REG_BIT_COUNT: kmer_cfg = data[hlc_pkg::KMER_W-1:0];
			hlc_pkg::REG_THRESHOLD: thr_cfg = data[hlc_pkg::THR_W-1:0];
			hlc_pkg::REG_SEQ_TOTAL: total_cfg = data[hlc_pkg::TOTAL_W-1:0];
			hlc_pkg::REG_COMPRESS:  compress_cfg = data[0];
			default: ;
		endcase
	endtask

	// Wait until every word request is taken and every result has come, then
	// let the block finish any closing still in flight.
	task automatic drain();
		while (words_taken != words_pushed || expected_rows.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		bit [hlc_pkg::WORD_W-1:0] pool [4][ROW_WORDS];
		bit [hlc_pkg::WORD_W-1:0] cur [ROW_WORDS];
		logic [hlc_pkg::CFG_DATA_W-1:0] value;
		int ph, eb, nw, nrows, r, b, flips, pos, i, k, rand_base;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: single-word rows, extremes of the word
		write_reg(hlc_pkg::REG_BIT_COUNT, 16'd64);
		write_reg(hlc_pkg::REG_THRESHOLD, 16'd0);
		write_reg(hlc_pkg::REG_SEQ_TOTAL, 16'd8);
		write_reg(hlc_pkg::REG_COMPRESS, 16'd1);
		@(negedge clk) cfg_valid <= 1'b0;
		push_word('1);
		push_word('0);
		push_word('1);
		push_word(64'h1);
		push_word(64'hAAAA_AAAA_AAAA_AAAA);
		push_word(64'h5555_5555_5555_5555);
		drain();

		// widest threshold: any row joins; total lowered below the row count
		write_reg(hlc_pkg::REG_THRESHOLD, 16'd1024);
		write_reg(hlc_pkg::REG_SEQ_TOTAL, 16'd2);
		@(negedge clk) cfg_valid <= 1'b0;
		push_word(64'h00FF_00FF_0F0F_3C3C);
		push_word(64'h8000_0000_0000_0001);
		push_word(64'hFFFF_0000_FFFF_0000);
		drain();

		// zero bit count acts as one bit; zero row total acts as one
		write_reg(hlc_pkg::REG_BIT_COUNT, 16'd0);
		write_reg(hlc_pkg::REG_THRESHOLD, 16'd0);
		write_reg(hlc_pkg::REG_SEQ_TOTAL, 16'd0);
		@(negedge clk) cfg_valid <= 1'b0;
		push_word('1);
		drain();
		write_reg(hlc_pkg::REG_SEQ_TOTAL, 16'd16);
		@(negedge clk) cfg_valid <= 1'b0;
		push_word(64'hFFFF_FFFF_FFFF_FFFE);
		push_word('1);
		push_word(64'h2);
		drain();

		// two-word rows with a one-bit tail
		write_reg(hlc_pkg::REG_BIT_COUNT, 16'd65);
		@(negedge clk) cfg_valid <= 1'b0;
		push_word('1);
		push_word('1);
		push_word('0);
		push_word(64'hFFFF_FFFF_FFFF_FFFE);
		drain();

		// compression off: the row founds its own cluster
		write_reg(hlc_pkg::REG_COMPRESS, 16'd0);
		@(negedge clk) cfg_valid <= 1'b0;
		push_word(64'h0123_4567_89AB_CDEF);
		push_word('1);
		drain();
		write_reg(hlc_pkg::REG_COMPRESS, 16'd1);

		// bit count shrunk mid-row: the next word closes the row
		write_reg(hlc_pkg::REG_BIT_COUNT, 16'd200);
		@(negedge clk) cfg_valid <= 1'b0;
		push_word(64'hDEAD_BEEF_F00D_CAFE);
		push_word('1);
		drain();
		write_reg(hlc_pkg::REG_BIT_COUNT, 16'd64);
		@(negedge clk) cfg_valid <= 1'b0;
		push_word(64'hFEDC_BA98_7654_3210);
		drain();

		// Random phases. The first fills the store past its capacity, the
		// second runs full-width rows with an oversized bit count.
		rand_base = words_pushed;
		for (ph = 0; words_pushed - rand_base < RANDOM_WORDS; ph++) begin
			if (ph == 0) begin
				write_reg(hlc_pkg::REG_BIT_COUNT, 16'd64);
				write_reg(hlc_pkg::REG_THRESHOLD, 16'd0);
				write_reg(hlc_pkg::REG_SEQ_TOTAL, 16'hFFFF);
				write_reg(hlc_pkg::REG_COMPRESS, 16'd1);
			end else if (ph == 1) begin
				write_reg(hlc_pkg::REG_BIT_COUNT, 16'd2047);
				write_reg(hlc_pkg::REG_THRESHOLD, 16'd40);
				write_reg(hlc_pkg::REG_SEQ_TOTAL, 16'd2);
			end else begin
				if ($urandom_range(0, 99) < 70) begin
					r = $urandom_range(0, 99);
					if (r < 5)
						value = 16'd0;
					else if (r < 60)
						value = 16'($urandom_range(1, 128));
					else if (r < 85)
						value = 16'($urandom_range(129, 400));
					else if (r < 91)
						value = 16'd1024;
					else if (r < 95)
						value = 16'd2047;
					else
						value = 16'($urandom_range(401, 1023));
					// junk above the field is dropped
					if ($urandom_range(0, 9) == 0)
						value[15:11] = 5'($urandom);
					write_reg(hlc_pkg::REG_BIT_COUNT, value);
				end
				eb = (kmer_cfg == 0) ? 1 : ((kmer_cfg > ROW_BITS) ? ROW_BITS : int'(kmer_cfg));
				if ($urandom_range(0, 99) < 70) begin
					r = $urandom_range(0, 99);
					if (r < 15)
						value = 16'd0;
					else if (r < 60)
						value = 16'($urandom_range(0, eb / 8 + 2));
					else if (r < 80)
						value = 16'($urandom_range(0, eb / 2));
					else if (r < 90)
						value = 16'd1024;
					else if (r < 95)
						value = 16'd2047;
					else
						value = 16'($urandom_range(0, 2047));
					write_reg(hlc_pkg::REG_THRESHOLD, value);
				end
				if ($urandom_range(0, 99) < 60) begin
					r = $urandom_range(0, 99);
					if (r < 5)
						value = 16'd0;
					else if (r < 10)
						value = 16'd1;
					else if (r < 60)
						value = 16'($urandom_range(2, 40));
					else if (r < 85)
						value = 16'($urandom_range(41, 400));
					else if (r < 93)
						value = 16'hFFFF;
					else
						value = 16'($urandom);
					write_reg(hlc_pkg::REG_SEQ_TOTAL, value);
				end
				if ($urandom_range(0, 99) < 50) begin
					value = ($urandom_range(0, 99) < 85) ? 16'd1 : 16'd0;
					if ($urandom_range(0, 9) == 0)
						value[15:1] = 15'($urandom);
					write_reg(hlc_pkg::REG_COMPRESS, value);
				end
			end
			@(negedge clk) cfg_valid <= 1'b0;
			quiet_phase = (ph > 1) && ($urandom_range(0, 3) == 0);

			eb = (kmer_cfg == 0) ? 1 : ((kmer_cfg > ROW_BITS) ? ROW_BITS : int'(kmer_cfg));
			nw = (eb - 1) / 64 + 1;
			for (b = 0; b < 4; b++)
				for (k = 0; k < ROW_WORDS; k++)
					pool[b][k] = rand_word();
			if ($urandom_range(0, 3) == 0)
				for (k = 0; k < ROW_WORDS; k++)
					pool[3][k] = '1;
			if (ph == 0)
				nrows = 40;
			else if (ph == 1)
				nrows = 3;
			else
				nrows = $urandom_range(1, 1 + 40 / nw);

			for (i = 0; i < nrows; i++) begin
				r = (ph < 2) ? 0 : $urandom_range(0, 99);
				b = (ph == 1) ? 0 : $urandom_range(0, 3);
				if (ph == 0 || r >= 90) begin
					// noise row
					for (k = 0; k < nw; k++)
						cur[k] = rand_word();
				end else if (r >= 80) begin
					for (k = 0; k < nw; k++)
						cur[k] = r[0] ? '1 : '0;
				end else begin
					// well-formed: a base row with a few flipped bits
					for (k = 0; k < nw; k++)
						cur[k] = pool[b][k];
					flips = $urandom_range(0, (r < 40) ? 2 : 10);
					repeat (flips) begin
						pos = $urandom_range(0, eb - 1);
						cur[pos / 64][pos % 64] ^= 1'b1;
					end
				end
				for (k = 0; k < nw; k++)
					push_word(cur[k]);
			end
			// leave a row open now and then so the next setting lands mid-row
			if (ph > 1 && nw > 1 && $urandom_range(0, 99) < 15)
				repeat ($urandom_range(1, nw - 1))
					push_word(rand_word());
			drain();
		end

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#15ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
